// ===== rtl/core/timed_wait_queue_defines.svh =====
// Assertion macros used by the timed wait queue top level.
`ifndef TIMED_WAIT_QUEUE_DEFINES_SVH
`define TIMED_WAIT_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define TWQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define TWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/twq_pkg.sv =====
// Types, codes and controller interface of the timed wait queue.
package twq_pkg;

  localparam int HANDLE_W = 16;
  localparam int TICKS_W  = 16;

  // Input operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_TAKE   = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle;
    logic [TICKS_W-1:0]  wait_ticks;
  } twq_in_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] task_id;
    logic                last;
  } twq_out_t;

  // One stored queue entry
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TICKS_W-1:0]  remaining;
  } twq_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_TAKE,
    ST_TAKE_OUT,
    ST_SCAN,
    ST_FINISH
  } twq_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic append;
    logic take_rd;
    logic take_out;
    logic scan;
    logic finish;
  } twq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic scan_done;
  } twq_stat_t;

endpackage

// ===== rtl/core/timed_wait_queue.sv =====
// Timed wait queue top level: ordered FIFO of handles with tick timeouts.
// Append passes through the APPEND state, take through TAKE and, unless empty, TAKE_OUT; busy drops with the result.
// Lookup and tick: scan one entry per cycle through the single memory read port,
// then give the final result from the FINISH state.
// Tick expiries come out at most one per cycle during the scan; results cannot stall.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
`include "timed_wait_queue_defines.svh"

module timed_wait_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  twq_pkg::twq_in_t  in_beat,
  output logic              out_valid,
  output twq_pkg::twq_out_t out_beat
);
  import twq_pkg::*;

  twq_cmd_t  cmd;
  twq_stat_t stat;

  twq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_beat.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  twq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  // The final beat of an item frees the block in the same cycle
  `TWQ_ASSERT_SAME(a_last_frees, clk, rst_n, out_valid && out_beat.last, !busy,
                   "final beat while busy")
  // Beats ahead of the final one come only while the scan runs
  `TWQ_ASSERT_SAME(a_early_busy, clk, rst_n, out_valid && !out_beat.last, busy,
                   "early beat while idle")
  // Only tick expiries may come as several beats
  `TWQ_ASSERT_SAME(a_single_beat, clk, rst_n, out_valid && (out_beat.kind != KIND_TICK),
                   out_beat.last, "multi-beat non-tick result")
  // An accepted item keeps the block busy in the next cycle
  `TWQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy,
                   "accept did not raise busy")

endmodule

// ===== rtl/core/twq_ctrl.sv =====
// Sequencing state machine of the timed wait queue.
module twq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        op,
  input  twq_pkg::twq_stat_t stat,
  output twq_pkg::twq_cmd_t  cmd,
  output logic              busy
);
  import twq_pkg::*;

  twq_state_t state_r;
  twq_state_t state_nxt;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pick the next state and issue commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          unique case (op)
            OP_APPEND: state_nxt = ST_APPEND;
            OP_TAKE:   state_nxt = ST_TAKE;
            OP_LOOKUP: state_nxt = ST_SCAN;
            OP_TICK:   state_nxt = ST_SCAN;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_TAKE: begin
        cmd.take_rd = 1'b1;
        state_nxt   = stat.empty ? ST_IDLE : ST_TAKE_OUT;
      end
      ST_TAKE_OUT: begin
        cmd.take_out = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/twq_datapath.sv =====
// Entry store, ring pointers, scan logic and result register of the queue.
module twq_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  twq_pkg::twq_in_t   in_beat,
  input  twq_pkg::twq_cmd_t  cmd,
  output twq_pkg::twq_stat_t stat,
  output logic               out_valid,
  output twq_pkg::twq_out_t  out_beat
);
  import twq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;

  // Entry store
  twq_entry_t mem [QUEUE_DEPTH];

  // Latched item
  logic [1:0]          op_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TICKS_W-1:0]  wait_r;

  // Ring and scan control
  logic [AW-1:0] head_r,  head_nxt;
  logic [CW-1:0] occ_r,   occ_nxt;
  logic [CW-1:0] idx_r,   idx_nxt;
  logic [CW-1:0] keep_r,  keep_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          found_r,  found_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [HANDLE_W-1:0] pend_id_r, pend_id_nxt;
  twq_entry_t    rd_data_r;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  twq_out_t  out_beat_r,  out_beat_nxt;

  // Memory port signals
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  twq_entry_t    wr_data;

  logic               issue;
  logic [TICKS_W-1:0] rem;

  // Ring address: base plus offset, folded once past the depth
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
    logic [SW-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SW'(QUEUE_DEPTH)) begin
      sum = sum - SW'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign stat.empty     = (occ_r == '0);
  assign stat.scan_done = (idx_r == occ_r) && !rd_vld_r;

  assign issue = idx_r < occ_r;
  assign rem   = rd_data_r.remaining;

  // Work out the next state of the datapath
  always_comb begin
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    idx_nxt       = idx_r;
    keep_nxt      = keep_r;
    rd_vld_nxt    = 1'b0;
    found_nxt     = found_r;
    pend_vld_nxt  = pend_vld_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = 1'b0;
    out_beat_nxt  = out_beat_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = ring_addr(head_r, occ_r[AW-1:0]);
    wr_data       = '{handle: handle_r, remaining: wait_r};

    if (cmd.load) begin
      idx_nxt      = '0;
      keep_nxt     = '0;
      found_nxt    = 1'b0;
      pend_vld_nxt = 1'b0;
    end

    // Append at the tail or flag full
    if (cmd.append) begin
      out_valid_nxt = 1'b1;
      if (occ_r == CW'(QUEUE_DEPTH)) begin
        out_beat_nxt = '{kind: KIND_APPEND, status: STATUS_FULL, task_id: '0, last: 1'b1};
      end else begin
        wr_en        = 1'b1;
        occ_nxt      = occ_r + 1'b1;
        out_beat_nxt = '{kind: KIND_APPEND, status: STATUS_OK, task_id: '0, last: 1'b1};
      end
    end

    // Read the oldest entry or report empty
    if (cmd.take_rd) begin
      if (occ_r == '0) begin
        out_valid_nxt = 1'b1;
        out_beat_nxt  = '{kind: KIND_TAKE, status: STATUS_NONE, task_id: '0, last: 1'b1};
      end else begin
        rd_en   = 1'b1;
        rd_addr = head_r;
      end
    end

    // Drop the oldest entry and return its handle
    if (cmd.take_out) begin
      head_nxt      = ring_addr(head_r, AW'(1));
      occ_nxt       = occ_r - 1'b1;
      out_valid_nxt = 1'b1;
      out_beat_nxt  = '{kind: KIND_TAKE, status: STATUS_OK,
                        task_id: rd_data_r.handle, last: 1'b1};
    end

    if (cmd.scan) begin
      // Issue one read per cycle, oldest first
      if (issue) begin
        rd_en      = 1'b1;
        rd_addr    = ring_addr(head_r, idx_r[AW-1:0]);
        idx_nxt    = idx_r + 1'b1;
        rd_vld_nxt = 1'b1;
      end
      // Process the entry read in the previous cycle
      if (rd_vld_r) begin
        if (op_r == OP_LOOKUP) begin
          if (rd_data_r.handle == handle_r) begin
            found_nxt = 1'b1;
          end
        end else if (rem == TICKS_W'(1)) begin
          // Expired: flush the earlier expiry, hold this one back
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_beat_nxt  = '{kind: KIND_TICK, status: STATUS_OK,
                              task_id: pend_id_r, last: 1'b0};
          end
          pend_vld_nxt = 1'b1;
          pend_id_nxt  = rd_data_r.handle;
        end else begin
          // Survivor: compact toward the head, its count stepped down unless already zero
          wr_en    = 1'b1;
          wr_addr  = ring_addr(head_r, keep_r[AW-1:0]);
          wr_data  = '{handle: rd_data_r.handle,
                       remaining: (rem == '0) ? rem : rem - 1'b1};
          keep_nxt = keep_r + 1'b1;
        end
      end
    end

    // Close the scan with the final result
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (op_r == OP_LOOKUP) begin
        if (found_r) begin
          out_beat_nxt = '{kind: KIND_LOOKUP, status: STATUS_OK, task_id: handle_r,
                           last: 1'b1};
        end else begin
          out_beat_nxt = '{kind: KIND_LOOKUP, status: STATUS_NONE, task_id: '0,
                           last: 1'b1};
        end
      end else begin
        occ_nxt = keep_r;
        if (pend_vld_r) begin
          out_beat_nxt = '{kind: KIND_TICK, status: STATUS_OK, task_id: pend_id_r,
                           last: 1'b1};
        end else begin
          out_beat_nxt = '{kind: KIND_TICK, status: STATUS_NONE, task_id: '0,
                           last: 1'b1};
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      keep_r      <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      keep_r      <= keep_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_beat_r <= out_beat_nxt;
    if (cmd.load) begin
      op_r     <= in_beat.op;
      handle_r <= in_beat.handle;
      wait_r   <= in_beat.wait_ticks;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
